>>> sv/bpa_pkg.sv
// shared constants, codes, types and helper of the buddy page allocator
package bpa_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int TOP_RANK  = 16;
  localparam int PAGE_W    = 10;
  localparam int LINK_W    = 11;
  localparam int RANK_W    = 5;
  localparam int CNT_W     = 11;
  localparam int SPAN_W    = 17;
  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int MARK_W    = 2;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_PAGES);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 3'd0,
    CMD_FREE   = 3'd1,
    CMD_QRANK  = 3'd2,
    CMD_QCOUNT = 3'd3,
    CMD_INIT   = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2
  } status_t;

  typedef enum logic [MARK_W-1:0] {
    MARK_BODY  = 2'd0,
    MARK_FREE  = 2'd1,
    MARK_ALLOC = 2'd2
  } mark_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_BUILD, S_IDLE,
    S_A_SEARCH, S_A_SPLIT, S_A_SPLIT2,
    S_F_RD, S_F_CHK, S_F_LOOP, S_F_BCHK, S_F_MERGE, S_F_END,
    S_Q_RD, S_Q_CHK,
    S_SETRANK, S_PUSH1, S_PUSH2, S_UL1, S_UL2, S_UL3,
    S_DONE
  } state_t;

  // rank of the largest power-of-two block that fits in n pages
  function automatic logic [RANK_W-1:0] fit_rank(input logic [CNT_W-1:0] n);
    logic [RANK_W-1:0] rk;
    rk = RANK_W'(1);
    for (int b = 0; b < CNT_W; b++) begin
      if (n[b]) rk = RANK_W'(b + 1);
    end
    if (rk > RANK_W'(TOP_RANK)) rk = RANK_W'(TOP_RANK);
    return rk;
  endfunction

endpackage

>>> sv/bpa_req_if.sv
// request channel: command, rank and page
interface bpa_req_if;
  logic                        valid;
  logic                        ready;
  logic [bpa_pkg::CMD_W-1:0]   cmd;
  logic [bpa_pkg::RANK_W-1:0]  req_rank;
  logic [bpa_pkg::PAGE_W-1:0]  page_index;
  modport source (output valid, cmd, req_rank, page_index, input ready);
  modport sink (input valid, cmd, req_rank, page_index, output ready);
endinterface

>>> sv/bpa_rsp_if.sv
// result channel: status, allocated page and value
interface bpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bpa_pkg::STATUS_W-1:0]  status;
  logic [bpa_pkg::PAGE_W-1:0]    alloc_page;
  logic [bpa_pkg::CNT_W-1:0]     value;
  modport source (output valid, status, alloc_page, value, input ready);
  modport sink (input valid, status, alloc_page, value, output ready);
endinterface

>>> sv/bpa_cfg_if.sv
// configuration write channel for the page count register
interface bpa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bpa_pkg::CNT_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> sv/buddy_page_allocator.sv
// Buddy page allocator over a pool of up to 1024 pages.
// Channels: req (cmd, req_rank, page_index), rsp (status, alloc_page, value),
// cfg (page_count write). All move on valid and ready both high.
// One request is worked at a time; req.ready is high only when idle.
// Each request gives exactly one result on rsp.
// The work is done by a sequencer over four 1024-entry rams (rank, mark,
// next link, prev link), each with one write port and one registered read port:
//   query count: read from the list counters; query rank: one ram read
//   alloc: search over ranks (one rank a cycle) and a list unlink, then per
//     split level a rewrite of the block's pages in rank (one page a cycle),
//     the split and a list push
//   free: per merge level a buddy check, a list unlink and the pages rewritten in rank
//   init: a clearing pass over all 1024 entries, then per block its pages and a list push
// After reset the clearing pass and pool build for 1024 pages run
// with req.ready low; cfg writes are taken always.
// The result waits in an output register; a stalled rsp holds the
// sequencer in its final step until the register frees.
module buddy_page_allocator (
  input  logic     clk,
  input  logic     rst,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp,
  bpa_cfg_if.sink   cfg
);
  import bpa_pkg::*;

  localparam int AW = $clog2(MAX_PAGES);

  state_t state, state_next, ret_state, ret_state_next, push_ret, push_ret_next;

  logic [CMD_W-1:0]  cmd_q, cmd_q_next;
  logic [RANK_W-1:0] rq_q, rq_q_next;
  logic [PAGE_W-1:0] pg_q, pg_q_next;
  logic [RANK_W-1:0] k, k_next, r, r_next;
  logic [PAGE_W-1:0] blk, blk_next, bud, bud_next;
  logic [CNT_W-1:0]  ptr, ptr_next;
  logic [SPAN_W-1:0] set_end, set_end_next;
  logic [RANK_W-1:0] set_val, set_val_next;
  logic [PAGE_W-1:0] push_pg, push_pg_next;
  logic [RANK_W-1:0] push_r, push_r_next;
  logic [PAGE_W-1:0] ul_pg, ul_pg_next;
  logic [RANK_W-1:0] ul_r, ul_r_next;
  logic [LINK_W-1:0] ul_p, ul_p_next, ul_n, ul_n_next;
  logic [CNT_W-1:0]  left, left_next, start, start_next;
  logic [CNT_W-1:0]  pool_size, pool_size_next;
  logic [CNT_W-1:0]  page_count;
  logic              init_rst, init_rst_next;
  logic [LINK_W-1:0] head [TOP_RANK+1];
  logic [LINK_W-1:0] head_next [TOP_RANK+1];
  logic [CNT_W-1:0]  count [TOP_RANK+1];
  logic [CNT_W-1:0]  count_next [TOP_RANK+1];
  logic [STATUS_W-1:0] pend_st, pend_st_next;
  logic [PAGE_W-1:0]   pend_ap, pend_ap_next;
  logic [CNT_W-1:0]    pend_val, pend_val_next;
  logic                out_valid;
  logic [STATUS_W-1:0] out_st;
  logic [PAGE_W-1:0]   out_ap;
  logic [CNT_W-1:0]    out_val;
  logic                out_load;

  // ram ports
  logic              rank_we, mark_we, next_we, prev_we;
  logic [AW-1:0]     rank_wa, mark_wa, next_wa, prev_wa, rd_addr;
  logic [RANK_W-1:0] rank_wd, rank_rd;
  logic [MARK_W-1:0] mark_wd, mark_rd;
  logic [LINK_W-1:0] next_wd, next_rd, prev_wd, prev_rd;

  // scratch values
  logic [SPAN_W-1:0] span, tgt;
  logic [15:0]       bud_w;
  logic [CNT_W-1:0]  ptr_inc;
  logic [RANK_W-1:0] fit;
  logic [LINK_W-1:0] hd;

  bpa_ram #(.WIDTH(RANK_W), .DEPTH(MAX_PAGES)) u_rank (
    .clk(clk), .we(rank_we), .waddr(rank_wa), .wdata(rank_wd),
    .raddr(rd_addr), .rdata(rank_rd));
  bpa_ram #(.WIDTH(MARK_W), .DEPTH(MAX_PAGES)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
    .raddr(rd_addr), .rdata(mark_rd));
  bpa_ram #(.WIDTH(LINK_W), .DEPTH(MAX_PAGES)) u_next (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(rd_addr), .rdata(next_rd));
  bpa_ram #(.WIDTH(LINK_W), .DEPTH(MAX_PAGES)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .raddr(rd_addr), .rdata(prev_rd));

  assign req.ready  = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign rsp.valid  = out_valid;
  assign rsp.status = out_st;
  assign rsp.alloc_page = out_ap;
  assign rsp.value  = out_val;

  // page count register
  always_ff @(posedge clk) begin
    if (rst) begin
      page_count <= CNT_W'(MAX_PAGES);
    end else if (cfg.valid) begin
      page_count <= cfg.data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_st  <= pend_st;
      out_ap  <= pend_ap;
      out_val <= pend_val;
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ret_state <= S_IDLE;
      push_ret  <= S_IDLE;
      ptr       <= '0;
      init_rst  <= 1'b1;
      pool_size <= CNT_W'(MAX_PAGES);
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
      push_ret  <= push_ret_next;
      ptr       <= ptr_next;
      init_rst  <= init_rst_next;
      pool_size <= pool_size_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q    <= cmd_q_next;
    rq_q     <= rq_q_next;
    pg_q     <= pg_q_next;
    k        <= k_next;
    r        <= r_next;
    blk      <= blk_next;
    bud      <= bud_next;
    set_end  <= set_end_next;
    set_val  <= set_val_next;
    push_pg  <= push_pg_next;
    push_r   <= push_r_next;
    ul_pg    <= ul_pg_next;
    ul_r     <= ul_r_next;
    ul_p     <= ul_p_next;
    ul_n     <= ul_n_next;
    left     <= left_next;
    start    <= start_next;
    head     <= head_next;
    count    <= count_next;
    pend_st  <= pend_st_next;
    pend_ap  <= pend_ap_next;
    pend_val <= pend_val_next;
  end

  // next state, ram controls and datapath
  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    push_ret_next  = push_ret;
    cmd_q_next = cmd_q;  rq_q_next = rq_q;  pg_q_next = pg_q;
    k_next = k;  r_next = r;  blk_next = blk;  bud_next = bud;
    ptr_next = ptr;  set_end_next = set_end;  set_val_next = set_val;
    push_pg_next = push_pg;  push_r_next = push_r;
    ul_pg_next = ul_pg;  ul_r_next = ul_r;  ul_p_next = ul_p;  ul_n_next = ul_n;
    left_next = left;  start_next = start;
    pool_size_next = pool_size;
    init_rst_next  = init_rst;
    head_next  = head;
    count_next = count;
    pend_st_next = pend_st;  pend_ap_next = pend_ap;  pend_val_next = pend_val;
    out_load = 1'b0;
    rank_we = 1'b0;  rank_wa = ptr[AW-1:0];  rank_wd = set_val;
    mark_we = 1'b0;  mark_wa = blk;          mark_wd = MARK_BODY;
    next_we = 1'b0;  next_wa = push_pg;      next_wd = NIL;
    prev_we = 1'b0;  prev_wa = push_pg;      prev_wd = NIL;
    rd_addr = ul_pg;
    span    = '0;
    tgt     = '0;
    bud_w   = '0;
    ptr_inc = ptr + CNT_W'(1);
    fit     = fit_rank(left);
    hd      = head[push_r];

    case (state)
      // wipe all page entries and lists
      S_CLEAR: begin
        rank_we = 1'b1;  rank_wd = '0;
        mark_we = 1'b1;  mark_wa = ptr[AW-1:0];  mark_wd = MARK_BODY;
        next_we = 1'b1;  next_wa = ptr[AW-1:0];
        prev_we = 1'b1;  prev_wa = ptr[AW-1:0];
        for (int i = 0; i <= TOP_RANK; i++) begin
          head_next[i]  = NIL;
          count_next[i] = '0;
        end
        ptr_next = ptr_inc;
        if (ptr == CNT_W'(MAX_PAGES - 1)) begin
          left_next  = pool_size;
          start_next = '0;
          state_next = S_BUILD;
        end
      end
      // carve the pool into descending aligned blocks
      S_BUILD: begin
        if (left == '0) begin
          if (init_rst) begin
            init_rst_next = 1'b0;
            state_next    = S_IDLE;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          span           = SPAN_W'(1) << (fit - RANK_W'(1));
          ptr_next       = start;
          set_end_next   = SPAN_W'(start) + span;
          set_val_next   = fit;
          mark_we        = 1'b1;
          mark_wa        = start[AW-1:0];
          mark_wd        = MARK_FREE;
          push_pg_next   = start[PAGE_W-1:0];
          push_r_next    = fit;
          push_ret_next  = S_BUILD;
          ret_state_next = S_PUSH1;
          start_next     = start + span[CNT_W-1:0];
          left_next      = left - span[CNT_W-1:0];
          state_next     = S_SETRANK;
        end
      end
      // take a request
      S_IDLE: begin
        if (req.valid) begin
          cmd_q_next    = req.cmd;
          rq_q_next     = req.req_rank;
          pg_q_next     = req.page_index;
          pend_st_next  = ST_OK;
          pend_ap_next  = '0;
          pend_val_next = '0;
          state_next    = S_DONE;
          case (req.cmd)
            CMD_ALLOC: begin
              if (req.req_rank == '0 || req.req_rank > RANK_W'(TOP_RANK)) begin
                pend_st_next = ST_INVALID;
              end else begin
                k_next     = req.req_rank;
                state_next = S_A_SEARCH;
              end
            end
            CMD_FREE:  state_next = S_F_RD;
            CMD_QRANK: state_next = S_Q_RD;
            CMD_QCOUNT: begin
              if (req.req_rank == '0 || req.req_rank > RANK_W'(TOP_RANK)) begin
                pend_st_next = ST_INVALID;
              end else begin
                pend_val_next = count[req.req_rank];
              end
            end
            CMD_INIT: begin
              if (page_count == '0) begin
                pend_st_next = ST_INVALID;
              end else begin
                pool_size_next = (page_count > CNT_W'(MAX_PAGES)) ?
                                 CNT_W'(MAX_PAGES) : page_count;
                ptr_next   = '0;
                state_next = S_CLEAR;
              end
            end
            default: pend_st_next = ST_INVALID;
          endcase
        end
      end
      // smallest non-empty list at or above the requested rank
      S_A_SEARCH: begin
        if (k > RANK_W'(TOP_RANK)) begin
          pend_st_next = ST_NOSPACE;
          state_next   = S_DONE;
        end else if (head[k] != NIL) begin
          blk_next       = head[k][PAGE_W-1:0];
          ul_pg_next     = head[k][PAGE_W-1:0];
          ul_r_next      = k;
          ret_state_next = S_A_SPLIT;
          state_next     = S_UL1;
        end else begin
          k_next = k + RANK_W'(1);
        end
      end
      // split one level: relabel the block at the lower rank
      S_A_SPLIT: begin
        if (k > rq_q) begin
          span           = SPAN_W'(1) << (k - RANK_W'(1));
          ptr_next       = CNT_W'(blk);
          set_end_next   = SPAN_W'(blk) + span;
          set_val_next   = k - RANK_W'(1);
          ret_state_next = S_A_SPLIT2;
          state_next     = S_SETRANK;
        end else begin
          mark_we      = 1'b1;
          mark_wa      = blk;
          mark_wd      = MARK_ALLOC;
          pend_ap_next = blk;
          state_next   = S_DONE;
        end
      end
      // push the right half
      S_A_SPLIT2: begin
        span   = SPAN_W'(1) << (k - RANK_W'(2));
        tgt    = SPAN_W'(blk) + span;
        k_next = k - RANK_W'(1);
        if (tgt < SPAN_W'(MAX_PAGES)) begin
          mark_we       = 1'b1;
          mark_wa       = tgt[AW-1:0];
          mark_wd       = MARK_FREE;
          push_pg_next  = tgt[PAGE_W-1:0];
          push_r_next   = k - RANK_W'(1);
          push_ret_next = S_A_SPLIT;
          state_next    = S_PUSH1;
        end else begin
          state_next = S_A_SPLIT;
        end
      end
      // free: read the page entry
      S_F_RD: begin
        rd_addr    = pg_q;
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        if (CNT_W'(pg_q) >= pool_size || mark_rd != MARK_ALLOC ||
            rank_rd == '0 || rank_rd > RANK_W'(TOP_RANK)) begin
          pend_st_next = ST_INVALID;
          state_next   = S_DONE;
        end else begin
          mark_we    = 1'b1;
          mark_wa    = pg_q;
          mark_wd    = MARK_BODY;
          blk_next   = pg_q;
          r_next     = rank_rd;
          state_next = S_F_LOOP;
        end
      end
      // look at the buddy of the current block
      S_F_LOOP: begin
        bud_w = 16'(blk) ^ (16'(1) << (r - RANK_W'(1)));
        if (r >= RANK_W'(TOP_RANK) || bud_w >= 16'(pool_size)) begin
          state_next = S_F_END;
        end else begin
          bud_next   = bud_w[PAGE_W-1:0];
          rd_addr    = bud_w[PAGE_W-1:0];
          state_next = S_F_BCHK;
        end
      end
      S_F_BCHK: begin
        if (mark_rd != MARK_FREE || rank_rd != r) begin
          state_next = S_F_END;
        end else begin
          ul_pg_next     = bud;
          ul_r_next      = r;
          ret_state_next = S_F_MERGE;
          state_next     = S_UL1;
        end
      end
      // merge with the buddy and relabel
      S_F_MERGE: begin
        mark_we = 1'b1;
        mark_wa = bud;
        mark_wd = MARK_BODY;
        span    = SPAN_W'(1) << r;
        if (bud < blk) begin
          blk_next     = bud;
          ptr_next     = CNT_W'(bud);
          set_end_next = SPAN_W'(bud) + span;
        end else begin
          ptr_next     = CNT_W'(blk);
          set_end_next = SPAN_W'(blk) + span;
        end
        r_next         = r + RANK_W'(1);
        set_val_next   = r + RANK_W'(1);
        ret_state_next = S_F_LOOP;
        state_next     = S_SETRANK;
      end
      S_F_END: begin
        mark_we       = 1'b1;
        mark_wa       = blk;
        mark_wd       = MARK_FREE;
        push_pg_next  = blk;
        push_r_next   = r;
        push_ret_next = S_DONE;
        state_next    = S_PUSH1;
      end
      // rank query
      S_Q_RD: begin
        rd_addr    = pg_q;
        state_next = S_Q_CHK;
      end
      S_Q_CHK: begin
        if (CNT_W'(pg_q) >= pool_size || rank_rd == '0) begin
          pend_st_next = ST_INVALID;
        end else begin
          pend_val_next = CNT_W'(rank_rd);
        end
        state_next = S_DONE;
      end
      // rewrite the rank of a page range, one page a cycle
      S_SETRANK: begin
        rank_we = 1'b1;
        ptr_next = ptr_inc;
        if (SPAN_W'(ptr_inc) >= set_end || ptr_inc >= pool_size) begin
          state_next = ret_state;
        end
      end
      // push a block on its list
      S_PUSH1: begin
        next_we = 1'b1;
        next_wd = hd;
        prev_we = 1'b1;
        if (hd != NIL) begin
          state_next = S_PUSH2;
        end else begin
          head_next[push_r]  = LINK_W'(push_pg);
          count_next[push_r] = count[push_r] + CNT_W'(1);
          state_next         = push_ret;
        end
      end
      S_PUSH2: begin
        prev_we            = 1'b1;
        prev_wa            = hd[PAGE_W-1:0];
        prev_wd            = LINK_W'(push_pg);
        head_next[push_r]  = LINK_W'(push_pg);
        count_next[push_r] = count[push_r] + CNT_W'(1);
        state_next         = push_ret;
      end
      // unlink a block from its list
      S_UL1: begin
        rd_addr    = ul_pg;
        state_next = S_UL2;
      end
      S_UL2: begin
        ul_p_next = prev_rd;
        ul_n_next = next_rd;
        if (prev_rd != NIL) begin
          next_we = 1'b1;
          next_wa = prev_rd[PAGE_W-1:0];
          next_wd = next_rd;
        end else begin
          head_next[ul_r] = next_rd;
        end
        if (next_rd != NIL) begin
          state_next = S_UL3;
        end else begin
          count_next[ul_r] = count[ul_r] - CNT_W'(1);
          state_next       = ret_state;
        end
      end
      S_UL3: begin
        prev_we          = 1'b1;
        prev_wa          = ul_n[PAGE_W-1:0];
        prev_wd          = ul_p;
        count_next[ul_r] = count[ul_r] - CNT_W'(1);
        state_next       = ret_state;
      end
      // hand the result to the output register
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // unlink only ever runs on a non-empty list
  a_unlink_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_UL2) |-> (count[ul_r] != '0))
    else $error("unlink from an empty free list");

  // rank rewrites stay inside the pool
  a_setrank_in_pool: assert property (@(posedge clk) disable iff (rst)
    (state == S_SETRANK) |-> (ptr < pool_size))
    else $error("rank rewrite beyond the pool");

  // a split always has a lower rank to go to
  a_split_rank: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_SPLIT2) |-> (k >= RANK_W'(2) && k > rq_q))
    else $error("split below rank one");

  // an accepted request always leaves idle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != S_IDLE))
    else $error("request accepted without work");
endmodule

>>> sv/bpa_ram.sv
// generic simple dual-port ram with registered read
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
